### hdl/shcev_pkg.sv
// Package for the step hazard evaluator: field widths, mode and function codes,
// and the word and configuration structs shared by the head, the cells and the top level.
// No dependencies.
package shcev_pkg;

   // fixed field widths
   localparam int DATA_W     = 32;
   localparam int OUT_W      = 40;
   localparam int IDX_W      = 5;
   localparam int MODE_W     = 2;
   localparam int ACTIVE_W   = 6;
   localparam int REQ_DATA_W = 104;   // 101 bits of fields, padded to whole bytes
   localparam int RSP_DATA_W = 80;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // default parameter values
   localparam int SUPPORT_DEPTH_DEF = 32;
   localparam int FRACTION_BITS_DEF = 16;

   // largest value an output sum may take
   localparam logic [OUT_W-1:0] OUT_MAX = '1;

   // model codes; the spare code acts as bathtub
   localparam logic [MODE_W-1:0] MODE_INC   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_DEC   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_BATH  = 2'd2;
   localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

   // function codes carried in tuser
   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_EVAL = 1'b1;

   // word travelling down the chain
   typedef struct packed {
      logic              valid;
      logic              func;
      logic [IDX_W-1:0]  index;
      logic [DATA_W-1:0] loc;
      logic [DATA_W-1:0] wgt;
      logic [DATA_W-1:0] t;
   } query_type;

   // running sums of one evaluate word
   typedef struct packed {
      logic             valid;
      logic [OUT_W-1:0] hazard;
      logic [OUT_W-1:0] cum;
      logic             sat;
   } acc_type;

   // configuration registers
   typedef struct packed {
      logic [MODE_W-1:0]   mode;
      logic [DATA_W-1:0]   base;
      logic [DATA_W-1:0]   infl;
      logic [ACTIVE_W-1:0] active;
   } cfg_type;

endpackage

### hdl/shcev_head.sv
// Head of the evaluation chain: registers the incoming word and forms the base terms
// (base rate and base rate times time) that seed the running sums. Uses shcev_pkg.
module shcev_head import shcev_pkg::*; #(
   parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  cfg_type               cfg,
   input  logic                  req_tvalid,
   input  logic                  req_tuser,   // func
   input  logic [REQ_DATA_W-1:0] req_tdata,   // entry_index, support_location,
                                              // support_weight, query_time
   output query_type             q_dn,
   output acc_type               acc_dn
);

   localparam int PROD_W = 2*DATA_W;
   localparam int TERM_W = PROD_W - FRACTION_BITS;

   query_type         q_ff, q_in;
   logic [TERM_W-1:0] base_term_ff, base_term_in;
   logic              eval_ff, eval_in;
   acc_type           acc_ff, acc_in;
   logic [PROD_W-1:0] base_prod;

   // unpack the incoming word
   always_comb begin
      q_in.valid = req_tvalid;
      q_in.func  = req_tuser;
      q_in.index = req_tdata[IDX_W-1:0];
      q_in.loc   = req_tdata[IDX_W +: DATA_W];
      q_in.wgt   = req_tdata[IDX_W+DATA_W +: DATA_W];
      q_in.t     = req_tdata[IDX_W+2*DATA_W +: DATA_W];
   end

   // base rate times time, truncated
   always_comb begin
      base_prod    = {{DATA_W{1'b0}}, q_ff.t} * {{DATA_W{1'b0}}, cfg.base};
      base_term_in = base_prod[PROD_W-1:FRACTION_BITS];
      eval_in      = q_ff.valid && (q_ff.func == FUNC_EVAL);
   end

   // seed sums, clipped to the output range
   always_comb begin
      acc_in.valid  = eval_ff;
      acc_in.hazard = {{(OUT_W-DATA_W){1'b0}}, cfg.base};
      if (base_term_ff > {{(TERM_W-OUT_W){1'b0}}, OUT_MAX}) begin
         acc_in.cum = OUT_MAX;
         acc_in.sat = 1'b1;
      end else begin
         acc_in.cum = base_term_ff[OUT_W-1:0];
         acc_in.sat = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_ff.valid   <= 1'b0;
         eval_ff      <= 1'b0;
         acc_ff.valid <= 1'b0;
      end else if (en) begin
         q_ff         <= q_in;
         base_term_ff <= base_term_in;
         eval_ff      <= eval_in;
         acc_ff       <= acc_in;
      end
   end

   assign q_dn   = q_ff;
   assign acc_dn = acc_ff;

endmodule

### hdl/shcev_cell.sv
// One support cell: holds one table entry, works out its share for a passing query and
// adds it to the running sums after its operand and product registers. Uses shcev_pkg.
module shcev_cell import shcev_pkg::*; #(
   parameter int CELL_INDEX    = 0,
   parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      en,
   input  cfg_type   cfg,
   input  query_type q_up,
   output query_type q_dn,
   input  acc_type   acc_up,
   output acc_type   acc_dn
);

   localparam int PROD_W = 2*DATA_W;
   localparam int TERM_W = PROD_W - FRACTION_BITS;
   localparam int SUM_W  = TERM_W + 1;
   localparam int HSUM_W = OUT_W + 1;

   logic [DATA_W-1:0] loc_ff, loc_in, wgt_ff, wgt_in;
   query_type         q_ff;
   logic [DATA_W-1:0] x_ff, x_in, w_ff, w_in, hw_ff, hw_in, hw2_ff;
   logic [TERM_W-1:0] term_ff, term_in;
   acc_type           acc_ff, acc_in;

   logic              active, hit, t_gt_a;
   logic [DATA_W-1:0] t, th, a, span, t_m_a, a_m_t, r, p_part, q_part, x_sel;
   logic [PROD_W-1:0] prod;
   logic [HSUM_W-1:0] h_sum;
   logic [SUM_W-1:0]  c_sum;
   logic              h_ovf, c_ovf;

   // entry load when a load word for this slot passes
   always_comb begin
      loc_in = loc_ff;
      wgt_in = wgt_ff;
      if (q_up.valid && (q_up.func == FUNC_LOAD) && (int'(q_up.index) == CELL_INDEX)) begin
         loc_in = q_up.loc;
         wgt_in = q_up.wgt;
      end
   end

   // share of this entry: hit for the hazard, time span for the cumulative
   always_comb begin
      t      = q_up.t;
      th     = loc_ff;
      a      = cfg.infl;
      active = int'(cfg.active) > CELL_INDEX;
      t_gt_a = t > a;
      t_m_a  = t - a;
      a_m_t  = a - t;
      span   = t_gt_a ? t_m_a : a_m_t;
      r      = a - th;
      p_part = (a > th) ? r : '0;
      q_part = (t_m_a > th) ? (t_m_a - th) : '0;
      hit    = 1'b0;
      x_sel  = '0;
      unique case (cfg.mode) inside
         MODE_INC: begin
            hit   = th <= t;
            x_sel = hit ? (t - th) : '0;
         end
         MODE_DEC: begin
            hit   = th >= t;
            x_sel = hit ? t : th;
         end
         MODE_BATH, MODE_SPARE: begin
            hit = th <= span;
            if (!t_gt_a) begin
               if (th < a) x_sel = (t < r) ? t : r;
               else        x_sel = '0;
            end else begin
               x_sel = p_part + q_part;
            end
         end
      endcase
      x_in  = active ? x_sel : '0;
      w_in  = active ? wgt_ff : '0;
      hw_in = (active && hit) ? wgt_ff : '0;
   end

   // product stage
   always_comb begin
      prod    = {{DATA_W{1'b0}}, x_ff} * {{DATA_W{1'b0}}, w_ff};
      term_in = prod[PROD_W-1:FRACTION_BITS];
   end

   // saturating accumulate
   always_comb begin
      h_sum = {1'b0, acc_up.hazard} + {{(HSUM_W-DATA_W){1'b0}}, hw2_ff};
      c_sum = {{(SUM_W-OUT_W){1'b0}}, acc_up.cum} + {1'b0, term_ff};
      h_ovf = h_sum > {1'b0, OUT_MAX};
      c_ovf = c_sum > {{(SUM_W-OUT_W){1'b0}}, OUT_MAX};
      acc_in.valid  = acc_up.valid;
      acc_in.hazard = h_ovf ? OUT_MAX : h_sum[OUT_W-1:0];
      acc_in.cum    = c_ovf ? OUT_MAX : c_sum[OUT_W-1:0];
      acc_in.sat    = acc_up.sat | h_ovf | c_ovf;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_ff.valid   <= 1'b0;
         acc_ff.valid <= 1'b0;
      end else if (en) begin
         loc_ff  <= loc_in;
         wgt_ff  <= wgt_in;
         q_ff    <= q_up;
         x_ff    <= x_in;
         w_ff    <= w_in;
         hw_ff   <= hw_in;
         term_ff <= term_in;
         hw2_ff  <= hw_ff;
         acc_ff  <= acc_in;
      end
   end

   assign q_dn   = q_ff;
   assign acc_dn = acc_ff;

   // sums never shrink along the chain
   assert property (@(posedge clock) disable iff (reset)
      (en && acc_up.valid) |=> (acc_ff.valid && (acc_ff.hazard >= $past(acc_up.hazard))
                                && (acc_ff.cum >= $past(acc_up.cum))))
      else $error("running sum decreased in support cell");

   // a clip flag once raised stays raised
   assert property (@(posedge clock) disable iff (reset)
      (en && acc_up.valid && acc_up.sat) |=> acc_ff.sat)
      else $error("saturation flag lost in support cell");

   // a stalled chain holds its sums
   assert property (@(posedge clock) disable iff (reset)
      !en |=> ($stable(acc_ff.valid) && $stable(acc_ff.hazard) && $stable(acc_ff.cum)))
      else $error("support cell sums moved while stalled");

endmodule

### hdl/step_hazard_and_cumulative_eval.sv
// Step hazard and cumulative hazard evaluator, top level. Uses shcev_pkg, shcev_head
// and shcev_cell.
//
// Input words arrive on req_*: tuser is the function (load or evaluate), tdata the entry
// index, location, weight and query time. A load word writes one support entry and gives
// no result; an evaluate word gives one result word on rsp_* with the hazard, the
// cumulative hazard and a clip flag. Registers are set over the csr_* port, and the user
// must set them only while idle; the block does not enforce it.
// Words move through a head stage and a chain of SUPPORT_DEPTH cells, one cell a cycle
// while the chain advances; each cell holds one entry and adds its share to the sums
// after its operand and product registers. One word is taken every cycle unless the
// receiver stalls. Loads travel in the same chain, so they take effect in word order.
// The whole chain advances only while the output register is empty or being taken:
// when the receiver stalls, req_tready drops and every stage holds.
// Reset clears csr registers and all valid flags; table entries stay unknown until loaded.
module step_hazard_and_cumulative_eval import shcev_pkg::*; #(
   parameter int SUPPORT_DEPTH = SUPPORT_DEPTH_DEF,
   parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // input words
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic                  req_tuser,   // func
   input  logic [REQ_DATA_W-1:0] req_tdata,   // entry_index, support_location,
                                              // support_weight, query_time
   // result words
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic                  rsp_tuser,   // saturated
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // hazard_rate, cumulative_hazard
   // register port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam logic [1:0] REG_MODE   = 2'd0;
   localparam logic [1:0] REG_BASE   = 2'd1;
   localparam logic [1:0] REG_INFL   = 2'd2;
   localparam logic [1:0] REG_ACTIVE = 2'd3;

   cfg_type   cfg_ff, cfg_in;
   acc_type   out_ff;
   logic      advance, csr_wr;
   query_type q_link   [SUPPORT_DEPTH+1];
   acc_type   acc_link [SUPPORT_DEPTH+1];

   // register writes
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         unique case (csr_paddr[3:2])
            REG_MODE:   cfg_in.mode   = csr_pwdata[MODE_W-1:0];
            REG_BASE:   cfg_in.base   = csr_pwdata[DATA_W-1:0];
            REG_INFL:   cfg_in.infl   = csr_pwdata[DATA_W-1:0];
            REG_ACTIVE: cfg_in.active = csr_pwdata[ACTIVE_W-1:0];
         endcase
      end
   end

   // register reads
   always_comb begin
      unique case (csr_paddr[3:2])
         REG_MODE:   csr_prdata = {{(CSR_DATA_W-MODE_W){1'b0}}, cfg_ff.mode};
         REG_BASE:   csr_prdata = cfg_ff.base;
         REG_INFL:   csr_prdata = cfg_ff.infl;
         REG_ACTIVE: csr_prdata = {{(CSR_DATA_W-ACTIVE_W){1'b0}}, cfg_ff.active};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) cfg_ff <= '0;
      else       cfg_ff <= cfg_in;
   end

   // chain advances when the output register can take a word; no word taken in reset
   assign advance    = !out_ff.valid || rsp_tready;
   assign req_tready = advance && !reset;

   shcev_head #(
      .FRACTION_BITS(FRACTION_BITS)
   ) u_head (
      .clock      (clock),
      .reset      (reset),
      .en         (advance),
      .cfg        (cfg_ff),
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .q_dn       (q_link[0]),
      .acc_dn     (acc_link[0])
   );

   for (genvar i = 0; i < SUPPORT_DEPTH; i++) begin : g_cell
      shcev_cell #(
         .CELL_INDEX    (i),
         .FRACTION_BITS (FRACTION_BITS)
      ) u_cell (
         .clock  (clock),
         .reset  (reset),
         .en     (advance),
         .cfg    (cfg_ff),
         .q_up   (q_link[i]),
         .q_dn   (q_link[i+1]),
         .acc_up (acc_link[i]),
         .acc_dn (acc_link[i+1])
      );
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff.valid <= 1'b0;
      end else if (advance) begin
         out_ff <= acc_link[SUPPORT_DEPTH];
      end
   end

   assign rsp_tvalid = out_ff.valid;
   assign rsp_tuser  = out_ff.sat;
   assign rsp_tdata  = {out_ff.cum, out_ff.hazard};

endmodule
